// ===== sv/mohs_pkg.sv =====
// ============================================================================
// mohs_pkg
// Shared types, codes and helpers of the modem handshake sequencer.
// ============================================================================
package mohs_pkg;

   // Reply timer width
   localparam int WAIT_BITS = 16;
   localparam logic [31:0] WAIT_MAX32 = 32'(((64'd1 << WAIT_BITS) - 64'd1));

   // Command codes (req_tuser)
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_CONNECT = 2'd1;
   localparam logic [1:0] CMD_LINE    = 2'd2;
   localparam logic [1:0] CMD_RESET   = 2'd3;

   // Reply line kinds
   localparam logic [2:0] LK_EMPTY    = 3'd0;
   localparam logic [2:0] LK_ATZ_ECHO = 3'd1;
   localparam logic [2:0] LK_OK       = 3'd2;
   localparam logic [2:0] LK_MAKER    = 3'd3;
   localparam logic [2:0] LK_CGMI     = 3'd4;
   localparam logic [2:0] LK_CONNECT  = 3'd5;
   localparam logic [2:0] LK_ERROR    = 3'd6;
   localparam logic [2:0] LK_OTHER    = 3'd7;

   // Handshake phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_ATZ      = 3'd1;
   localparam logic [2:0] PH_QUERY    = 3'd2;
   localparam logic [2:0] PH_MODE     = 3'd3;
   localparam logic [2:0] PH_LINKED   = 3'd4;
   localparam logic [2:0] PH_DTR_LOW  = 3'd5;
   localparam logic [2:0] PH_DTR_HIGH = 3'd6;
   localparam logic [2:0] PH_CR       = 3'd7;

   // Outgoing commands
   localparam logic [2:0] SEND_NONE  = 3'd0;
   localparam logic [2:0] SEND_ATZ   = 3'd1;
   localparam logic [2:0] SEND_CGMI  = 3'd2;
   localparam logic [2:0] SEND_OBEX  = 3'd3;
   localparam logic [2:0] SEND_CR    = 3'd4;

   // DTR actions
   localparam logic [1:0] DTR_KEEP  = 2'd0;
   localparam logic [1:0] DTR_DROP  = 2'd1;
   localparam logic [1:0] DTR_RAISE = 2'd2;

   // Link status
   localparam logic [1:0] LINK_IDLE      = 2'd0;
   localparam logic [1:0] LINK_CONNECTED = 2'd1;
   localparam logic [1:0] LINK_ERROR     = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_REFUSED = 2'd1;
   localparam logic [1:0] ERR_TIMEOUT = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [2:0] CSR_FIRST_TRIES    = 3'd0;
   localparam logic [2:0] CSR_RECOVERY_TRIES = 3'd1;
   localparam logic [2:0] CSR_ATZ_WAIT       = 3'd2;
   localparam logic [2:0] CSR_REPLY_WAIT     = 3'd3;
   localparam logic [2:0] CSR_DTR_WAIT       = 3'd4;

   typedef struct packed {
      logic [3:0]  first_atz_tries;
      logic [3:0]  recovery_atz_tries;
      logic [15:0] atz_wait_ms;
      logic [15:0] reply_wait_ms;
      logic [15:0] dtr_wait_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]           phase;
      logic [3:0]           tries_left;
      logic [WAIT_BITS-1:0] wait_left;
      logic                 wait_armed;
      logic [1:0]           status;
   } state_type;

   typedef struct packed {
      logic [2:0] handshake_state;
      logic       flush_input;
      logic       pass_line;
      logic       connected_event;
      logic [1:0] error_code;
      logic [1:0] link_status;
      logic [1:0] dtr_action;
      logic [2:0] send_command;
   } result_type;

   // Load value of the timer, saturated to the timer width
   function automatic logic [WAIT_BITS-1:0] wait_load(input logic [15:0] ms);
      logic [31:0] wide;
      wide = {16'd0, ms};
      if (wide > WAIT_MAX32) begin
         return '1;
      end else begin
         return WAIT_BITS'(wide);
      end
   endfunction

endpackage

// ===== sv/mohs_csr.sv =====
// ============================================================================
// mohs_csr
// Configuration registers: attempt budgets and timeouts.
// ============================================================================
module mohs_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [mohs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [15:0]                            csr_data,
   output mohs_pkg::cfg_type                      cfg
);
   import mohs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_TRIES:    cfg_in.first_atz_tries    = csr_data[3:0];
            CSR_RECOVERY_TRIES: cfg_in.recovery_atz_tries = csr_data[3:0];
            CSR_ATZ_WAIT:       cfg_in.atz_wait_ms        = csr_data;
            CSR_REPLY_WAIT:     cfg_in.reply_wait_ms      = csr_data;
            CSR_DTR_WAIT:       cfg_in.dtr_wait_ms        = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_atz_tries    <= 4'd10;
         cfg_ff.recovery_atz_tries <= 4'd15;
         cfg_ff.atz_wait_ms        <= 16'd200;
         cfg_ff.reply_wait_ms      <= 16'd300;
         cfg_ff.dtr_wait_ms        <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/mohs_step.sv =====
// ============================================================================
// mohs_step
// Next-state and result logic for one word of the handshake sequencer.
// ============================================================================
module mohs_step (
   input  mohs_pkg::cfg_type    cfg,
   input  mohs_pkg::state_type  state_cur,
   input  logic [1:0]           command,
   input  logic [2:0]           line_kind,
   input  logic                 port_ok,
   output mohs_pkg::state_type  state_in,
   output mohs_pkg::result_type result_in
);
   import mohs_pkg::*;

   state_type  nxt;
   result_type res;

   always_comb begin
      nxt = state_cur;
      res = '0;
      case (command)
         CMD_TICK: begin
            if (state_cur.wait_armed) begin
               if (state_cur.wait_left <= WAIT_BITS'(1)) begin
                  nxt.wait_left  = '0;
                  nxt.wait_armed = 1'b0;
                  // timeout action of the current phase, may rearm
                  case (state_cur.phase)
                     PH_ATZ: begin
                        if (state_cur.tries_left > 4'd1) begin
                           nxt.tries_left   = state_cur.tries_left - 4'd1;
                           res.send_command = SEND_ATZ;
                           nxt.wait_left    = wait_load(cfg.atz_wait_ms);
                           nxt.wait_armed   = 1'b1;
                        end else begin
                           nxt.tries_left = 4'd0;
                           nxt.phase      = PH_DTR_LOW;
                           res.dtr_action = DTR_DROP;
                           nxt.wait_left  = wait_load(cfg.dtr_wait_ms);
                           nxt.wait_armed = 1'b1;
                        end
                     end
                     PH_QUERY, PH_MODE: begin
                        nxt.phase      = PH_IDLE;
                        nxt.status     = LINK_ERROR;
                        res.error_code = ERR_TIMEOUT;
                     end
                     PH_DTR_LOW: begin
                        nxt.phase      = PH_DTR_HIGH;
                        res.dtr_action = DTR_RAISE;
                        nxt.wait_left  = wait_load(cfg.dtr_wait_ms);
                        nxt.wait_armed = 1'b1;
                     end
                     PH_DTR_HIGH: begin
                        nxt.phase        = PH_CR;
                        res.send_command = SEND_CR;
                        nxt.wait_left    = wait_load(cfg.dtr_wait_ms);
                        nxt.wait_armed   = 1'b1;
                     end
                     PH_CR: begin
                        nxt.phase        = PH_ATZ;
                        res.send_command = SEND_ATZ;
                        nxt.tries_left   = cfg.recovery_atz_tries;
                        nxt.wait_left    = wait_load(cfg.atz_wait_ms);
                        nxt.wait_armed   = 1'b1;
                     end
                     default: ;
                  endcase
               end else begin
                  nxt.wait_left = state_cur.wait_left - WAIT_BITS'(1);
               end
            end
         end
         CMD_CONNECT: begin
            if (!port_ok) begin
               nxt.status     = LINK_ERROR;
               res.error_code = ERR_REFUSED;
            end else if (state_cur.phase == PH_IDLE) begin
               res.send_command = SEND_ATZ;
               nxt.tries_left   = cfg.first_atz_tries;
               nxt.phase        = PH_ATZ;
               nxt.wait_left    = wait_load(cfg.atz_wait_ms);
               nxt.wait_armed   = 1'b1;
            end
         end
         CMD_LINE: begin
            case (state_cur.phase)
               PH_ATZ: begin
                  if (line_kind inside {LK_EMPTY, LK_ATZ_ECHO}) begin
                     // echo or blank, keep waiting
                  end else if (line_kind == LK_OK) begin
                     res.send_command = SEND_CGMI;
                     nxt.phase        = PH_QUERY;
                     nxt.wait_left    = wait_load(cfg.reply_wait_ms);
                     nxt.wait_armed   = 1'b1;
                  end else begin
                     nxt.phase      = PH_IDLE;
                     nxt.status     = LINK_ERROR;
                     res.error_code = ERR_REFUSED;
                  end
               end
               PH_QUERY: begin
                  if (line_kind inside {LK_EMPTY, LK_MAKER, LK_CGMI}) begin
                     // maker name and echo are ignored
                  end else if (line_kind == LK_OK) begin
                     res.send_command = SEND_OBEX;
                     nxt.phase        = PH_MODE;
                     nxt.wait_left    = wait_load(cfg.reply_wait_ms);
                     nxt.wait_armed   = 1'b1;
                  end else begin
                     nxt.phase      = PH_IDLE;
                     nxt.status     = LINK_ERROR;
                     res.error_code = ERR_REFUSED;
                  end
               end
               PH_MODE: begin
                  if (line_kind == LK_CONNECT) begin
                     nxt.status          = LINK_CONNECTED;
                     nxt.phase           = PH_LINKED;
                     res.connected_event = 1'b1;
                  end else if (line_kind == LK_ERROR) begin
                     nxt.phase      = PH_IDLE;
                     nxt.status     = LINK_ERROR;
                     res.error_code = ERR_REFUSED;
                  end
               end
               PH_LINKED: res.pass_line   = 1'b1;
               default:   res.flush_input = 1'b1;
            endcase
         end
         default: begin
            nxt.phase      = PH_IDLE;
            nxt.tries_left = 4'd0;
            nxt.wait_left  = '0;
            nxt.wait_armed = 1'b0;
            nxt.status     = LINK_IDLE;
         end
      endcase
      res.link_status     = nxt.status;
      res.handshake_state = nxt.phase;
   end

   assign state_in  = nxt;
   assign result_in = res;

endmodule

// ===== sv/modem_obex_handshake_fsm.sv =====
// ============================================================================
// modem_obex_handshake_fsm
// Sequences a modem into object-exchange mode from classified reply words.
// ============================================================================
// An accepted req word reaches its rsp word through the input register, then the
// result register, with the state update in the single step between.
// Throughput: one word per cycle; the input register stalls only while the
// result register holds a word that rsp_tready has not taken.
// Reset: synchronous, clears the handshake state, timer and both registers'
// valid flags, and restores the configuration defaults.
module modem_obex_handshake_fsm (
   input  logic                                clock,
   input  logic                                reset,
   // req: line_kind[2:0], port_ok[3], zero[7:4]
   input  logic [7:0]                          req_tdata,
   // req: command[1:0]
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp: send_command[2:0], dtr_action[4:3], link_status[6:5], error_code[8:7],
   //      connected_event[9], pass_line[10], flush_input[11],
   //      handshake_state[14:12], zero[15]
   output logic [15:0]                         rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mohs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                         csr_data
);
   import mohs_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;

   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [2:0] in_kind_ff;
   logic       in_port_ok_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign csr_ready = 1'b1;

   mohs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mohs_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .command   (in_cmd_ff),
      .line_kind (in_kind_ff),
      .port_ok   (in_port_ok_ff),
      .state_in  (state_in),
      .result_in (result_in)
   );

   // word moves from input to result register when the latter is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, tries_left: 4'd0, wait_left: '0,
                           wait_armed: 1'b0, status: LINK_IDLE};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff     <= req_tuser;
         in_kind_ff    <= req_tdata[2:0];
         in_port_ok_ff <= req_tdata[3];
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

endmodule

// ===== sv/mohs_checker.sv =====
// ============================================================================
// mohs_checker
// Port-level checks of the handshake sequencer, bound to the top level.
// ============================================================================
module mohs_checker (
   input logic        clock,
   input logic        reset,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);
   import mohs_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // entering binary mode shows connected status and phase
   a_connect: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |->
         rsp_tdata[6:5] == LINK_CONNECTED && rsp_tdata[14:12] == PH_LINKED)
      else $error("connect event without connected state");

   // any error raised leaves the link in error status
   a_error_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8:7] != ERR_NONE |-> rsp_tdata[6:5] == LINK_ERROR)
      else $error("error code without error status");

   // a passed line only while linked, and never together with a flush
   a_pass_linked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[14:12] == PH_LINKED && !rsp_tdata[11])
      else $error("line passed outside the linked state");

endmodule

bind modem_obex_handshake_fsm mohs_checker u_mohs_checker (.*);
